### hdl/srtf_pkg.sv
package srtf_pkg;

  // Fixed field widths
  localparam int unsigned PidW  = 8;
  localparam int unsigned ArrW  = 16;
  localparam int unsigned BstW  = 16;
  localparam int unsigned TimeW = 24;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  // Result kinds, carried on the master tuser
  typedef enum logic [2:0] {
    ST_LOADED = 3'd0,
    ST_FULL   = 3'd1,
    ST_LATE   = 3'd2,
    ST_IDLE   = 3'd3,
    ST_RAN    = 3'd4
  } status_e;

  // One process table entry
  typedef struct packed {
    logic [PidW-1:0] pid;
    logic [ArrW-1:0] arrival;
    logic [BstW-1:0] remaining;
    logic [BstW-1:0] burst;
    logic            done;
  } slot_t;

endpackage

### hdl/shortest_remaining_time_scheduler.sv
// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid_i/tready_o      tuser: mode; tdata: proc_id, arrival, burst
// m_axis   out  m_axis_tvalid_o/tready_i      tuser: status; tdata: now_time .. waiting
//
// A load goes from accept through S_RESULT to the result register.
// A tick that runs a process does one table read per slot through the single read port
// of the slot memory, then write-back, turnaround, result.
// A tick with nothing eligible skips the turnaround step.
// Reset (rst_ni low, async) empties the table and sets time to zero.
// A new word is taken while the previous result waits on m_axis.
module shortest_remaining_time_scheduler
  import srtf_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] proc_id, [23:8] arrival, [39:24] burst
  input  logic [39:0]  s_axis_tdata_i,
  // [0] mode
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [23:0] now_time, [31:24] run_id, [32] switched, [33] finished,
  // [57:34] completion_time, [81:58] turnaround, [105:82] waiting
  output logic [111:0] m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]   m_axis_tuser_o
);

  localparam int unsigned AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_WRITE  = 5'b00100,
    S_FIN    = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  // Control registers
  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic              last_vld_q, last_vld_d;
  logic [PidW-1:0]   last_id_q, last_id_d;
  logic              found_q, found_d;
  logic              out_vld_q, out_vld_d;

  // Datapath registers
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  slot_t             best_q, best_d;
  status_e           status_q, status_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic              switched_q, switched_d;
  logic              finished_q, finished_d;
  logic [TimeW-1:0]  tat_q, tat_d;
  status_e           out_status_q, out_status_d;
  logic [111:0]      out_data_q, out_data_d;

  // Slot memory
  slot_t             slot_mem_q [MAX_PROCS];
  slot_t             rd_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  slot_t             wr_data;

  // Input word fields
  logic              in_mode;
  logic [PidW-1:0]   in_pid;
  logic [ArrW-1:0]   in_arr;
  logic [BstW-1:0]   in_bst;
  logic              in_acc;

  logic [TimeW-1:0]  now_inc;
  logic              elig, better, last_slot;
  logic [TimeW:0]    wt_diff;
  logic [TimeW-1:0]  wt;
  logic [PidW-1:0]   res_id;
  logic [TimeW-1:0]  res_comp, res_tat, res_wt;

  assign in_mode = s_axis_tuser_i[0];
  assign in_pid  = s_axis_tdata_i[7:0];
  assign in_arr  = s_axis_tdata_i[23:8];
  assign in_bst  = s_axis_tdata_i[39:24];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  // Saturating time step
  assign now_inc = (now_q == TimeMax) ? now_q : now_q + 1'b1;

  // Scan compare on the entry just read
  assign elig   = !rd_q.done && ({{(TimeW-ArrW){1'b0}}, rd_q.arrival} <= now_q);
  assign better = !found_q || (rd_q.remaining < best_q.remaining) ||
                  ((rd_q.remaining == best_q.remaining) && (rd_q.pid < best_q.pid));
  assign last_slot = ((CW'(cmp_idx_q) + 1'b1) == cnt_q);

  // Waiting time, clamped at zero
  assign wt_diff = {1'b0, tat_q} - {{(TimeW+1-BstW){1'b0}}, best_q.burst};
  assign wt      = wt_diff[TimeW] ? '0 : wt_diff[TimeW-1:0];

  // Result fields, zero where not meaningful
  assign res_id   = (status_q == ST_RAN) ? best_q.pid : '0;
  assign res_comp = finished_q ? now_q : '0;
  assign res_tat  = finished_q ? tat_q : '0;
  assign res_wt   = finished_q ? wt : '0;

  // Memory read address: slot 0 on accept, next slot during scan
  assign rd_addr = (state_q == S_SCAN) ? cmp_idx_q + 1'b1 : '0;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    now_d        = now_q;
    last_vld_d   = last_vld_q;
    last_id_d    = last_id_q;
    found_d      = found_q;
    out_vld_d    = out_vld_q;
    cmp_idx_d    = cmp_idx_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    status_d     = status_q;
    start_d      = start_q;
    switched_d   = switched_q;
    finished_d   = finished_q;
    tat_d        = tat_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    wr_en        = 1'b0;
    wr_addr      = best_idx_q;
    wr_data      = best_q;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          start_d    = now_q;
          switched_d = 1'b0;
          finished_d = 1'b0;
          found_d    = 1'b0;
          cmp_idx_d  = '0;
          if (!in_mode) begin
            state_d = S_RESULT;
            priority if (cnt_q == CW'(MAX_PROCS)) begin
              status_d = ST_FULL;
            end else if ({{(TimeW-ArrW){1'b0}}, in_arr} < now_q) begin
              status_d = ST_LATE;
            end else begin
              status_d          = ST_LOADED;
              wr_en             = 1'b1;
              wr_addr           = cnt_q[AW-1:0];
              wr_data.pid       = in_pid;
              wr_data.arrival   = in_arr;
              wr_data.remaining = in_bst;
              wr_data.burst     = in_bst;
              wr_data.done      = (in_bst == '0);
              cnt_d             = cnt_q + 1'b1;
            end
          end else begin
            state_d = (cnt_q == '0) ? S_WRITE : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (elig && better) begin
          best_d     = rd_q;
          best_idx_d = cmp_idx_q;
          found_d    = 1'b1;
        end
        if (last_slot) begin
          state_d = S_WRITE;
        end else begin
          cmp_idx_d = cmp_idx_q + 1'b1;
        end
      end

      S_WRITE: begin
        now_d = now_inc;
        if (found_q) begin
          status_d          = ST_RAN;
          wr_en             = 1'b1;
          wr_data.remaining = best_q.remaining - 1'b1;
          wr_data.done      = (best_q.remaining == BstW'(1));
          switched_d        = !(last_vld_q && (last_id_q == best_q.pid));
          finished_d        = (best_q.remaining == BstW'(1));
          last_vld_d        = 1'b1;
          last_id_d         = best_q.pid;
          state_d           = S_FIN;
        end else begin
          status_d = ST_IDLE;
          state_d  = S_RESULT;
        end
      end

      S_FIN: begin
        // now_q already holds the completion time
        tat_d   = now_q - {{(TimeW-ArrW){1'b0}}, best_q.arrival};
        state_d = S_RESULT;
      end

      S_RESULT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d    = 1'b1;
          out_status_d = status_q;
          out_data_d   = {6'b0, res_wt, res_tat, res_comp, finished_q, switched_q,
                          res_id, start_q};
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      now_q      <= '0;
      last_vld_q <= 1'b0;
      last_id_q  <= '0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      now_q      <= now_d;
      last_vld_q <= last_vld_d;
      last_id_q  <= last_id_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    status_q     <= status_d;
    start_q      <= start_d;
    switched_q   <= switched_d;
    finished_q   <= finished_d;
    tat_q        <= tat_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

  // Slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
    rd_q <= slot_mem_q[rd_addr];
  end

`ifndef SYNTH
  // Table never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_PROCS))
    else $error("loaded count above table size");

  // Scan stays inside the loaded slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> CW'(cmp_idx_q) < cnt_q)
    else $error("scan index beyond loaded slots");

  // Time never goes backward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 now_q >= $past(now_q))
    else $error("time decreased");

  // A completion is only reported for a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q[33] |-> out_status_q == ST_RAN)
    else $error("finished without a run");
`endif

endmodule
